// ===== design/ptexp2_pkg.sv =====
// ----------------------------------------------------------------------------
// ptexp2_pkg: shared constants, types and exp2 table for the pitch transposer
// Holds field widths, divider constants and the Q1.30 2^f table builder.
// ----------------------------------------------------------------------------
package ptexp2_pkg;

    // Field widths of the ports.
    localparam int FREQ_W = 32;
    localparam int CENT_W = 20;
    localparam int SEMI_W = 16;
    localparam int OCT_W  = 13;
    localparam int QFRAC_W = 8;

    // Combined exponent in units of 1/307200 octave.
    localparam int E_W        = 25;
    localparam int SEMI_SCALE = 100;
    localparam int OCT_SCALE  = 1200;

    // Octave split: E = 1024 * (300 * q + rem) + low.
    localparam int LOW_W       = 10;
    localparam int U_W         = E_W - LOW_W;
    localparam int K_BIAS      = 32;
    localparam int OCT_DIV     = 300;
    localparam int U_BIAS      = OCT_DIV * K_BIAS;
    localparam int RECIP_W     = 12;
    localparam int RECIP_300   = 3495;
    localparam int RECIP_SHIFT = 20;
    localparam int Q_W         = 7;
    localparam int K_W         = 7;
    localparam int REM_W       = 10;
    localparam int RMD_W       = 9;
    localparam int R_W         = RMD_W + LOW_W;

    // Fraction F = floor(r * 16 / 75) by reciprocal multiply (exact on range).
    localparam int FRAC_W     = 16;
    localparam int FM_W       = 24;
    localparam int FRAC_MULT  = 14316558;
    localparam int FRAC_SHIFT = 26;

    // Exp2 table geometry.
    localparam int EXP2_TABLE_ADDR_BITS = 6;
    localparam int TBL_BITS = EXP2_TABLE_ADDR_BITS;
    localparam int TBL_SEGS = 1 << TBL_BITS;
    localparam int WGT_W    = FRAC_W - TBL_BITS;
    localparam int MANT_W   = 32;
    localparam int Q30_SH   = 30;

    // Scaling stage.
    localparam int PROD_W = FREQ_W + MANT_W;
    localparam int SH_W   = 8;

    // Pipeline depth.
    localparam int NUM_STAGES = 9;

    typedef logic [TBL_SEGS:0][MANT_W-1:0] exp2_tbl_t;

    // Floor square root of a 64-bit value, one result bit per iteration.
    function automatic logic [63:0] isqrt64(input logic [63:0] xin);
        logic [63:0] x;
        logic [63:0] res;
        logic [63:0] b;
        x   = xin;
        res = '0;
        b   = 64'd1 << 62;
        for (int i = 0; i < 32; i++)
        begin
            if (x >= res + b)
            begin
                x   = x - (res + b);
                res = (res >> 1) + b;
            end
            else
            begin
                res = res >> 1;
            end
            b = b >> 2;
        end
        return res;
    endfunction

    // Builds the Q1.30 table of 2^(i / TBL_SEGS), last entry exactly 2.0.
    function automatic exp2_tbl_t build_exp2_tbl();
        exp2_tbl_t   t;
        logic [63:0] step;
        logic [63:0] prev;
        step = 64'd2 << Q30_SH;
        for (int i = 0; i < TBL_BITS; i++)
        begin
            step = isqrt64(step << Q30_SH);
        end
        prev = 64'd1 << Q30_SH;
        t[0] = MANT_W'(prev);
        for (int i = 1; i < TBL_SEGS; i++)
        begin
            prev = (prev * step + (64'd1 << (Q30_SH - 1))) >> Q30_SH;
            t[i] = MANT_W'(prev);
        end
        t[TBL_SEGS] = MANT_W'(64'd2 << Q30_SH);
        return t;
    endfunction

    localparam exp2_tbl_t EXP2_TBL = build_exp2_tbl();

endpackage

// ===== design/ptexp2_offset.sv =====
// ----------------------------------------------------------------------------
// ptexp2_offset: offset combiner stage
// Floors the offsets when quantize is set and sums them into one exponent.
// ----------------------------------------------------------------------------
module ptexp2_offset (
    input  logic                                   clk,
    input  logic                                   en,
    input  logic                                   quantize,
    input  logic [ptexp2_pkg::FREQ_W-1:0]          freq_in,
    input  logic signed [ptexp2_pkg::CENT_W-1:0]   cent_offset,
    input  logic signed [ptexp2_pkg::SEMI_W-1:0]   semitone_offset,
    input  logic signed [ptexp2_pkg::OCT_W-1:0]    octave_offset,
    output logic [ptexp2_pkg::FREQ_W-1:0]          freq,
    output logic signed [ptexp2_pkg::E_W-1:0]      expo
);
    import ptexp2_pkg::*;

    logic signed [CENT_W-1:0] cent_fl;
    logic signed [SEMI_W-1:0] semi_fl;
    logic signed [OCT_W-1:0]  oct_fl;
    logic signed [E_W-1:0]    cent_ext;
    logic signed [E_W-1:0]    semi_ext;
    logic signed [E_W-1:0]    oct_ext;
    logic signed [E_W-1:0]    expo_next;
    logic signed [E_W-1:0]    expo_reg;
    logic [FREQ_W-1:0]        freq_reg;

    // Clearing the fraction bits floors each offset to a whole unit.
    always_comb
    begin
        cent_fl = cent_offset;
        semi_fl = semitone_offset;
        oct_fl  = octave_offset;
        if (quantize)
        begin
            cent_fl[QFRAC_W-1:0] = '0;
            semi_fl[QFRAC_W-1:0] = '0;
            oct_fl[QFRAC_W-1:0]  = '0;
        end
    end

    // E = cents + 100 * semitones + 1200 * octaves, exact in E_W bits.
    always_comb
    begin
        cent_ext  = E_W'(cent_fl);
        semi_ext  = E_W'(semi_fl);
        oct_ext   = E_W'(oct_fl);
        expo_next = cent_ext + semi_ext * E_W'(SEMI_SCALE) + oct_ext * E_W'(OCT_SCALE);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            expo_reg <= expo_next;
            freq_reg <= freq_in;
        end
    end

    assign expo = expo_reg;
    assign freq = freq_reg;

endmodule

// ===== design/ptexp2_split.sv =====
// ----------------------------------------------------------------------------
// ptexp2_split: octave split stages
// Splits the exponent into a whole octave count and a 16-bit fraction.
// ----------------------------------------------------------------------------
module ptexp2_split (
    input  logic                                 clk,
    input  logic [2:0]                           en,
    input  logic [ptexp2_pkg::FREQ_W-1:0]        freq_i,
    input  logic signed [ptexp2_pkg::E_W-1:0]    expo,
    output logic [ptexp2_pkg::FREQ_W-1:0]        freq_o,
    output logic signed [ptexp2_pkg::K_W-1:0]    oct_k,
    output logic [ptexp2_pkg::FRAC_W-1:0]        frac
);
    import ptexp2_pkg::*;

    // Stage A: biased coarse quotient estimate.
    logic [U_W-1:0]            u_next;
    logic [U_W+RECIP_W-1:0]    qa_prod;
    logic [Q_W-1:0]            qa_next;
    logic [U_W-1:0]            u_reg;
    logic [Q_W-1:0]            qa_reg;
    logic [LOW_W-1:0]          low_reg;
    logic [FREQ_W-1:0]         freq_a_reg;

    // Stage B: quotient correction and remainder.
    logic [U_W-1:0]            prod300;
    logic [U_W-1:0]            rem_full;
    logic [REM_W-1:0]          rem0;
    logic [REM_W-1:0]          rem;
    logic [Q_W-1:0]            q;
    logic signed [K_W-1:0]     k_next;
    logic [R_W-1:0]            r_next;
    logic signed [K_W-1:0]     k_b_reg;
    logic [R_W-1:0]            r_reg;
    logic [FREQ_W-1:0]         freq_b_reg;

    // Stage C: fraction by reciprocal multiply.
    logic [R_W+FM_W-1:0]       fprod;
    logic [FRAC_W-1:0]         frac_next;
    logic [FRAC_W-1:0]         frac_reg;
    logic signed [K_W-1:0]     k_c_reg;
    logic [FREQ_W-1:0]         freq_c_reg;

    // Floor of E / 1024 plus a bias that keeps the dividend positive.
    always_comb
    begin
        u_next  = expo[E_W-1:LOW_W] + U_W'(U_BIAS);
        qa_prod = (U_W+RECIP_W)'(u_next) * (U_W+RECIP_W)'(RECIP_300);
        qa_next = Q_W'(qa_prod >> RECIP_SHIFT);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            u_reg      <= u_next;
            qa_reg     <= qa_next;
            low_reg    <= expo[LOW_W-1:0];
            freq_a_reg <= freq_i;
        end
    end

    // The estimate is at most one low, so one compare and subtract fixes it.
    always_comb
    begin
        prod300  = U_W'(qa_reg) * U_W'(OCT_DIV);
        rem_full = u_reg - prod300;
        rem0     = rem_full[REM_W-1:0];
        if (rem0 >= REM_W'(OCT_DIV))
        begin
            q   = qa_reg + Q_W'(1);
            rem = rem0 - REM_W'(OCT_DIV);
        end
        else
        begin
            q   = qa_reg;
            rem = rem0;
        end
        k_next = K_W'(q) - K_W'(K_BIAS);
        r_next = {rem[RMD_W-1:0], low_reg};
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            k_b_reg    <= k_next;
            r_reg      <= r_next;
            freq_b_reg <= freq_a_reg;
        end
    end

    // F = floor(r * 65536 / 307200) = floor(r * 16 / 75).
    always_comb
    begin
        fprod     = (R_W+FM_W)'(r_reg) * (R_W+FM_W)'(FRAC_MULT);
        frac_next = fprod[FRAC_SHIFT +: FRAC_W];
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            frac_reg   <= frac_next;
            k_c_reg    <= k_b_reg;
            freq_c_reg <= freq_b_reg;
        end
    end

    assign frac   = frac_reg;
    assign oct_k  = k_c_reg;
    assign freq_o = freq_c_reg;

endmodule

// ===== design/ptexp2_interp.sv =====
// ----------------------------------------------------------------------------
// ptexp2_interp: exp2 interpolation stages
// Looks up two table entries and interpolates the Q1.30 mantissa 2^f.
// ----------------------------------------------------------------------------
module ptexp2_interp (
    input  logic                                 clk,
    input  logic [2:0]                           en,
    input  logic [ptexp2_pkg::FREQ_W-1:0]        freq_i,
    input  logic signed [ptexp2_pkg::K_W-1:0]    oct_k_i,
    input  logic [ptexp2_pkg::FRAC_W-1:0]        frac,
    output logic [ptexp2_pkg::FREQ_W-1:0]        freq_o,
    output logic signed [ptexp2_pkg::K_W-1:0]    oct_k_o,
    output logic [ptexp2_pkg::MANT_W-1:0]        mant
);
    import ptexp2_pkg::*;

    logic [TBL_BITS-1:0]       idx;
    logic [TBL_BITS:0]         idx_hi;
    logic [MANT_W-1:0]         lo_next;
    logic [MANT_W-1:0]         diff_next;
    logic [MANT_W-1:0]         lo_a_reg;
    logic [MANT_W-1:0]         diff_reg;
    logic [WGT_W-1:0]          w_reg;
    logic signed [K_W-1:0]     k_a_reg;
    logic [FREQ_W-1:0]         freq_a_reg;

    logic [MANT_W+WGT_W-1:0]   dprod_next;
    logic [MANT_W+WGT_W-1:0]   dprod_reg;
    logic [MANT_W-1:0]         lo_b_reg;
    logic signed [K_W-1:0]     k_b_reg;
    logic [FREQ_W-1:0]         freq_b_reg;

    logic [MANT_W-1:0]         mant_next;
    logic [MANT_W-1:0]         mant_reg;
    logic signed [K_W-1:0]     k_c_reg;
    logic [FREQ_W-1:0]         freq_c_reg;

    // Top fraction bits select the segment; its two end points are read.
    always_comb
    begin
        idx       = frac[FRAC_W-1 -: TBL_BITS];
        idx_hi    = (TBL_BITS+1)'(idx) + (TBL_BITS+1)'(1);
        lo_next   = EXP2_TBL[idx];
        diff_next = EXP2_TBL[idx_hi] - lo_next;
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            lo_a_reg   <= lo_next;
            diff_reg   <= diff_next;
            w_reg      <= frac[WGT_W-1:0];
            k_a_reg    <= oct_k_i;
            freq_a_reg <= freq_i;
        end
    end

    // Segment slope times the low fraction bits.
    assign dprod_next = (MANT_W+WGT_W)'(diff_reg) * (MANT_W+WGT_W)'(w_reg);

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            dprod_reg  <= dprod_next;
            lo_b_reg   <= lo_a_reg;
            k_b_reg    <= k_a_reg;
            freq_b_reg <= freq_a_reg;
        end
    end

    // Interpolated mantissa, truncated toward the lower entry.
    assign mant_next = lo_b_reg + MANT_W'(dprod_reg >> WGT_W);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            mant_reg   <= mant_next;
            k_c_reg    <= k_b_reg;
            freq_c_reg <= freq_b_reg;
        end
    end

    assign mant    = mant_reg;
    assign oct_k_o = k_c_reg;
    assign freq_o  = freq_c_reg;

endmodule

// ===== design/ptexp2_scale.sv =====
// ----------------------------------------------------------------------------
// ptexp2_scale: frequency scaling stages
// Multiplies the frequency by the mantissa, shifts by the octave count and
// saturates; the last register is the output register.
// ----------------------------------------------------------------------------
module ptexp2_scale (
    input  logic                                 clk,
    input  logic [1:0]                           en,
    input  logic [ptexp2_pkg::FREQ_W-1:0]        freq_i,
    input  logic signed [ptexp2_pkg::K_W-1:0]    oct_k,
    input  logic [ptexp2_pkg::MANT_W-1:0]        mant,
    output logic [ptexp2_pkg::FREQ_W-1:0]        freq_out,
    output logic                                 saturated
);
    import ptexp2_pkg::*;

    logic [PROD_W-1:0]         p_next;
    logic [PROD_W-1:0]         p_reg;
    logic signed [K_W-1:0]     k_reg;
    logic                      zero_reg;

    logic signed [SH_W-1:0]    sh;
    logic [PROD_W-1:0]         shifted;
    logic [FREQ_W-1:0]         freq_out_next;
    logic                      sat_next;
    logic [FREQ_W-1:0]         freq_out_reg;
    logic                      sat_reg;

    // Full 32 x 32 product of frequency and Q1.30 mantissa.
    assign p_next = PROD_W'(freq_i) * PROD_W'(mant);

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            p_reg    <= p_next;
            k_reg    <= oct_k;
            zero_reg <= (freq_i == '0);
        end
    end

    // Shift right by 30 - k. The offset ranges keep k at 28 or below, so a
    // left shift never occurs and the k above 30 arm only guards.
    always_comb
    begin
        sh            = SH_W'(Q30_SH) - SH_W'(k_reg);
        shifted       = '0;
        freq_out_next = '0;
        sat_next      = 1'b0;
        if (zero_reg)
        begin
            freq_out_next = '0;
            sat_next      = 1'b0;
        end
        else if (k_reg > K_W'(Q30_SH))
        begin
            freq_out_next = '1;
            sat_next      = 1'b1;
        end
        else
        begin
            if (sh < SH_W'(PROD_W))
            begin
                shifted = p_reg >> sh;
            end
            if (shifted[PROD_W-1:FREQ_W] != '0)
            begin
                freq_out_next = '1;
                sat_next      = 1'b1;
            end
            else
            begin
                freq_out_next = shifted[FREQ_W-1:0];
                sat_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            freq_out_reg <= freq_out_next;
            sat_reg      <= sat_next;
        end
    end

    assign freq_out  = freq_out_reg;
    assign saturated = sat_reg;

endmodule

// ===== design/pitch_transpose_exp2_top.sv =====
// ----------------------------------------------------------------------------
// pitch_transpose_exp2_top: equal-temperament pitch transposer
// Each request passes through every stage; low out_ready stalls the pipeline.
// Throughput: one request per cycle while out_ready is high; nine-stage pipeline.
// Reset clears all stage valid bits and sets quantize to 1; no clearing pass.
// ----------------------------------------------------------------------------
module pitch_transpose_exp2_top (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic                                 cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [ptexp2_pkg::FREQ_W-1:0]        freq_in,
    input  logic signed [ptexp2_pkg::CENT_W-1:0] cent_offset,
    input  logic signed [ptexp2_pkg::SEMI_W-1:0] semitone_offset,
    input  logic signed [ptexp2_pkg::OCT_W-1:0]  octave_offset,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [ptexp2_pkg::FREQ_W-1:0]        freq_out,
    output logic                                 saturated
);
    import ptexp2_pkg::*;

    logic                      quantize_reg;
    logic                      quantize_next;
    logic [NUM_STAGES:1]       vld_reg;
    logic [NUM_STAGES:1]       vld_next;
    logic [NUM_STAGES-1:0]     vld_in;
    logic [NUM_STAGES+1:1]     en;

    logic [FREQ_W-1:0]         freq_1;
    logic signed [E_W-1:0]     expo_1;
    logic [FREQ_W-1:0]         freq_4;
    logic signed [K_W-1:0]     k_4;
    logic [FRAC_W-1:0]         frac_4;
    logic [FREQ_W-1:0]         freq_7;
    logic signed [K_W-1:0]     k_7;
    logic [MANT_W-1:0]         mant_7;

    // Configuration register, always ready to take a write request.
    assign cfg_ready     = 1'b1;
    assign quantize_next = (cfg_valid && cfg_ready) ? cfg_data : quantize_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quantize_reg <= 1'b1;
        end
        else
        begin
            quantize_reg <= quantize_next;
        end
    end

    // A stage loads when it is empty or its content moves on downstream.
    always_comb
    begin
        en[NUM_STAGES+1] = out_ready;
        for (int i = NUM_STAGES; i >= 1; i--)
        begin
            en[i] = !vld_reg[i] || en[i+1];
        end
        vld_in[0] = in_valid;
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            vld_in[i] = vld_reg[i];
        end
        for (int i = 1; i <= NUM_STAGES; i++)
        begin
            vld_next[i] = en[i] ? vld_in[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = en[1];
    assign out_valid = vld_reg[NUM_STAGES];

    // Stage 1: offset combiner.
    ptexp2_offset u_offset (
        .clk             (clk),
        .en              (en[1]),
        .quantize        (quantize_reg),
        .freq_in         (freq_in),
        .cent_offset     (cent_offset),
        .semitone_offset (semitone_offset),
        .octave_offset   (octave_offset),
        .freq            (freq_1),
        .expo            (expo_1)
    );

    // Stages 2 to 4: octave count and fraction.
    ptexp2_split u_split (
        .clk    (clk),
        .en     (en[4:2]),
        .freq_i (freq_1),
        .expo   (expo_1),
        .freq_o (freq_4),
        .oct_k  (k_4),
        .frac   (frac_4)
    );

    // Stages 5 to 7: table lookup and interpolation.
    ptexp2_interp u_interp (
        .clk     (clk),
        .en      (en[7:5]),
        .freq_i  (freq_4),
        .oct_k_i (k_4),
        .frac    (frac_4),
        .freq_o  (freq_7),
        .oct_k_o (k_7),
        .mant    (mant_7)
    );

    // Stages 8 and 9: multiply, shift and saturate.
    ptexp2_scale u_scale (
        .clk       (clk),
        .en        (en[9:8]),
        .freq_i    (freq_7),
        .oct_k     (k_7),
        .mant      (mant_7),
        .freq_out  (freq_out),
        .saturated (saturated)
    );

endmodule
